// ----- sv/sps_pkg.sv -----
package sps_pkg;

  // default sizing
  localparam int NODE_COUNT_DEF  = 16;
  localparam int WEIGHT_BITS_DEF = 8;

  // fixed field widths of the channels
  localparam int REQ_BITS          = 2;
  localparam int FIELD_NODE_BITS   = 4;
  localparam int FIELD_WEIGHT_BITS = 8;
  localparam int OUT_DIST_BITS     = 12;

  // longest path report
  localparam int MAX_RESULTS = 16;

  localparam logic [OUT_DIST_BITS-1:0] DIST_SAT = '1;

  // request codes
  localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

  // adjacency store controls
  typedef struct packed {
    logic load;
    logic clear;
    logic rd;
  } adj_req_t;

  // minimum scan controls
  typedef struct packed {
    logic clr;
    logic vld;
    logic cand;
  } scan_ctl_t;

endpackage

// ----- sv/sps_if.sv -----
interface sps_in_if;
  import sps_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_BITS-1:0]          req_type;
  logic [FIELD_NODE_BITS-1:0]   edge_from;
  logic [FIELD_NODE_BITS-1:0]   edge_to;
  logic [FIELD_WEIGHT_BITS-1:0] edge_weight;
  logic [FIELD_NODE_BITS-1:0]   start_node;
  logic [FIELD_NODE_BITS-1:0]   end_node;

  modport source (
    output valid, req_type, edge_from, edge_to, edge_weight, start_node, end_node,
    input  ready
  );
  modport sink (
    input  valid, req_type, edge_from, edge_to, edge_weight, start_node, end_node,
    output ready
  );
endinterface

interface sps_out_if;
  import sps_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FIELD_NODE_BITS-1:0] path_node;
  logic [FIELD_NODE_BITS-1:0] via_node;
  logic [OUT_DIST_BITS-1:0]   path_distance;
  logic                       found;
  logic                       last;

  modport source (
    output valid, path_node, via_node, path_distance, found, last,
    input  ready
  );
  modport sink (
    input  valid, path_node, via_node, path_distance, found, last,
    output ready
  );
endinterface

// ----- sv/sps_adj_store.sv -----
module sps_adj_store #(
  parameter  int NODE_COUNT  = sps_pkg::NODE_COUNT_DEF,
  parameter  int WEIGHT_BITS = sps_pkg::WEIGHT_BITS_DEF,
  localparam int NB          = $clog2(NODE_COUNT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sps_pkg::adj_req_t      req,
  input  logic [NB-1:0]          load_from,
  input  logic [NB-1:0]          load_to,
  input  logic [WEIGHT_BITS-1:0] load_weight,
  input  logic [NB-1:0]          rd_from,
  input  logic [NB-1:0]          rd_to,
  output logic                   busy,
  output logic                   rd_valid,
  output logic [WEIGHT_BITS-1:0] rd_weight
);

  localparam int DEPTH = NODE_COUNT * NODE_COUNT;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    logic                   valid;
    logic [WEIGHT_BITS-1:0] weight;
  } adj_entry_t;

  adj_entry_t    mem [DEPTH];
  adj_entry_t    rd_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] rd_addr;

  // row-major: one row per source node
  assign load_addr = AW'(load_from) * AW'(NODE_COUNT) + AW'(load_to);
  assign rd_addr   = AW'(rd_from) * AW'(NODE_COUNT) + AW'(rd_to);

  // clearing sweep, one entry a cycle, after reset and on a clear request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end else if (req.clear) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.load) begin
      mem[load_addr] <= '{valid: 1'b1, weight: load_weight};
    end
    if (req.rd) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign busy      = clr_active_r;
  assign rd_valid  = rd_r.valid;
  assign rd_weight = rd_r.weight;

endmodule

// ----- sv/sps_min_scan.sv -----
module sps_min_scan #(
  parameter int NODE_BITS = $clog2(sps_pkg::NODE_COUNT_DEF),
  parameter int DIST_BITS = $clog2(sps_pkg::NODE_COUNT_DEF) + sps_pkg::WEIGHT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sps_pkg::scan_ctl_t   ctl,
  input  logic [NODE_BITS-1:0] idx,
  input  logic [DIST_BITS-1:0] cand_dist,
  input  logic [NODE_BITS-1:0] pred,
  output logic                 found,
  output logic [NODE_BITS-1:0] pick_idx,
  output logic [DIST_BITS-1:0] pick_dist,
  output logic [NODE_BITS-1:0] pick_pred
);

  logic                 found_r;
  logic [NODE_BITS-1:0] pick_idx_r;
  logic [DIST_BITS-1:0] pick_dist_r;
  logic [NODE_BITS-1:0] pick_pred_r;
  logic                 take;

  // entries arrive in ascending index order, strict compare keeps the lowest index on ties
  assign take = ctl.vld && ctl.cand && (!found_r || (cand_dist < pick_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clr) begin
      pick_idx_r  <= idx;
      pick_dist_r <= cand_dist;
      pick_pred_r <= pred;
    end
  end

  assign found     = found_r;
  assign pick_idx  = pick_idx_r;
  assign pick_dist = pick_dist_r;
  assign pick_pred = pick_pred_r;

endmodule

// ----- sv/shortest_path_search_unit.sv -----
// shortest path search over a stored weighted directed graph
//
// input channel (in_chan): one request per transfer. a load writes or overwrites one
// edge and finishes in the transfer cycle. a clear drops every edge with a sweep over
// all NODE_COUNT*NODE_COUNT entries, during which no request is taken. a query runs the
// search from start_node until end_node is settled, then reports the path.
// result channel (out_chan): one transfer per path node, end node first, each with its
// predecessor and distance (saturated at 4095); last is set on the start node's result
// or at the MAX_RESULTS cap. an unreachable end node gives one result with found low.
// sequence: a query first inits the node table, then runs settle steps until the end
// node is settled; each settle step is a full read pass of the node table for the
// minimum plus a pass over the source row of the adjacency store with read-modify-write
// of the node table. an unreachable end stops when a pass finds no candidate. on
// the path walk each path node takes a table read, then an output register load.
// the next request is taken once the final result sits in the output register, even
// while the receiver stalls it; results of the next query wait for it.
// reset: a clearing sweep over all NODE_COUNT*NODE_COUNT entries runs first, and
// in_chan.ready stays low until it finishes.
module shortest_path_search_unit #(
  parameter int NODE_COUNT  = sps_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = sps_pkg::WEIGHT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sps_in_if.sink    in_chan,
  sps_out_if.source out_chan
);
  import sps_pkg::*;

  localparam int NB        = $clog2(NODE_COUNT);
  // a settled distance sums the weights along a path that visits no node twice
  localparam int DB        = NB + WEIGHT_BITS;
  localparam int SW        = (DB > OUT_DIST_BITS) ? DB : OUT_DIST_BITS;
  localparam int OUT_LIMIT = (NODE_COUNT < MAX_RESULTS) ? NODE_COUNT : MAX_RESULTS;
  localparam int KB        = $clog2(MAX_RESULTS);
  localparam logic [NB-1:0] LAST_IDX  = NB'(NODE_COUNT - 1);
  localparam logic [KB-1:0] LAST_K    = KB'(OUT_LIMIT - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_SCAN_END,
    S_SETTLE,
    S_RELAX,
    S_RELAX_END,
    S_PATH_RD,
    S_PATH_EMIT,
    S_MISS
  } state_t;

  // per-node search record
  typedef struct packed {
    logic          reached;
    logic          settled;
    logic [DB-1:0] cost;
    logic [NB-1:0] pred;
  } node_t;

  state_t                     state_r;
  logic [NB-1:0]              idx_r;
  logic [NB-1:0]              rd_idx_r;
  logic                       rd_scan_r;
  logic                       rd_relax_r;
  logic [NB-1:0]              s_r;
  logic [NB-1:0]              e_r;
  logic [FIELD_NODE_BITS-1:0] end_raw_r;
  logic [NB-1:0]              cur_r;
  logic [KB-1:0]              k_r;

  logic                       out_valid_r;
  logic [FIELD_NODE_BITS-1:0] out_node_r;
  logic [FIELD_NODE_BITS-1:0] out_via_r;
  logic [OUT_DIST_BITS-1:0]   out_dist_r;
  logic                       out_found_r;
  logic                       out_last_r;

  // node table: one synchronous memory, registered read
  node_t         node_mem [NODE_COUNT];
  node_t         node_rd_r;
  logic          node_re;
  logic          node_we;
  logic [NB-1:0] node_raddr;
  logic [NB-1:0] node_waddr;
  node_t         node_wdata;

  logic                   accept;
  logic                   slot_free;
  logic                   out_load;
  logic                   s_ok;
  logic                   e_ok;
  logic                   from_ok;
  logic                   to_ok;
  adj_req_t               adj_req;
  logic                   adj_busy;
  logic                   adj_rd_valid;
  logic [WEIGHT_BITS-1:0] adj_rd_weight;
  scan_ctl_t              scan_ctl;
  logic                   pick_found;
  logic [NB-1:0]          pick_idx;
  logic [DB-1:0]          pick_dist;
  logic [NB-1:0]          pick_pred;
  logic [DB-1:0]          relax_dist;
  logic                   relax_upd;
  logic                   path_last;
  logic [SW-1:0]          dist_wide;
  logic [OUT_DIST_BITS-1:0] dist_sat;

  // requests are taken only in idle and never during a clearing sweep
  assign in_chan.ready = (state_r == S_IDLE) && !adj_busy;
  assign accept        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;
  // output register takes a new result this cycle
  assign out_load      = slot_free && ((state_r == S_PATH_EMIT) || (state_r == S_MISS));

  // node indexes beyond the graph
  assign s_ok    = int'(in_chan.start_node) < NODE_COUNT;
  assign e_ok    = int'(in_chan.end_node) < NODE_COUNT;
  assign from_ok = int'(in_chan.edge_from) < NODE_COUNT;
  assign to_ok   = int'(in_chan.edge_to) < NODE_COUNT;

  assign adj_req.load  = accept && (in_chan.req_type == REQ_LOAD) && from_ok && to_ok;
  assign adj_req.clear = accept && (in_chan.req_type == REQ_CLEAR);
  assign adj_req.rd    = (state_r == S_RELAX);

  sps_adj_store #(
    .NODE_COUNT  (NODE_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_adj (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (adj_req),
    .load_from   (NB'(in_chan.edge_from)),
    .load_to     (NB'(in_chan.edge_to)),
    .load_weight (WEIGHT_BITS'(in_chan.edge_weight)),
    .rd_from     (pick_idx),
    .rd_to       (idx_r),
    .busy        (adj_busy),
    .rd_valid    (adj_rd_valid),
    .rd_weight   (adj_rd_weight)
  );

  // minimum search over reached, unsettled nodes; cleared as a pass starts
  assign scan_ctl.clr  = (state_r == S_SCAN) && (idx_r == '0);
  assign scan_ctl.vld  = rd_scan_r;
  assign scan_ctl.cand = node_rd_r.reached && !node_rd_r.settled;

  sps_min_scan #(
    .NODE_BITS (NB),
    .DIST_BITS (DB)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .idx       (rd_idx_r),
    .cand_dist (node_rd_r.cost),
    .pred      (node_rd_r.pred),
    .found     (pick_found),
    .pick_idx  (pick_idx),
    .pick_dist (pick_dist),
    .pick_pred (pick_pred)
  );

  // relaxation of one out-edge of the settled node; the settled node itself reads back
  // settled, so a self loop never updates
  assign relax_dist = pick_dist + DB'(adj_rd_weight);
  assign relax_upd  = rd_relax_r && adj_rd_valid && !node_rd_r.settled &&
                      (!node_rd_r.reached || (relax_dist < node_rd_r.cost));

  // node table port selection per phase
  always_comb begin
    node_re    = 1'b0;
    node_raddr = idx_r;
    node_we    = 1'b0;
    node_waddr = idx_r;
    node_wdata = '0;
    unique case (state_r)
      S_INIT: begin
        node_we            = 1'b1;
        node_wdata.reached = (idx_r == s_r);
        node_wdata.pred    = (idx_r == s_r) ? s_r : '0;
      end
      S_SCAN, S_RELAX: begin
        node_re = 1'b1;
      end
      S_SETTLE: begin
        if (pick_found) begin
          node_we    = 1'b1;
          node_waddr = pick_idx;
          node_wdata = '{reached: 1'b1, settled: 1'b1, cost: pick_dist, pred: pick_pred};
        end
      end
      S_PATH_RD: begin
        node_re    = 1'b1;
        node_raddr = cur_r;
      end
      default: begin
      end
    endcase
    // write back comes in the cycle after its read, always at a different entry
    if (relax_upd) begin
      node_we    = 1'b1;
      node_waddr = rd_idx_r;
      node_wdata = '{reached: 1'b1, settled: 1'b0, cost: relax_dist, pred: pick_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_r <= node_mem[node_raddr];
    end
  end

  // path walk output
  assign path_last = (cur_r == s_r) || (k_r == LAST_K);
  assign dist_wide = SW'(node_rd_r.cost);
  assign dist_sat  = (dist_wide > SW'(DIST_SAT)) ? DIST_SAT : OUT_DIST_BITS'(dist_wide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      rd_idx_r    <= '0;
      rd_scan_r   <= 1'b0;
      rd_relax_r  <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_scan_r  <= (state_r == S_SCAN);
      rd_relax_r <= (state_r == S_RELAX);
      rd_idx_r   <= idx_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_chan.req_type == REQ_QUERY)) begin
            s_r       <= NB'(in_chan.start_node);
            e_r       <= NB'(in_chan.end_node);
            end_raw_r <= in_chan.end_node;
            idx_r     <= '0;
            k_r       <= '0;
            state_r   <= (s_ok && e_ok) ? S_INIT : S_MISS;
          end
        end
        S_INIT: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= S_SCAN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= S_SCAN_END;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SCAN_END: begin
          state_r <= S_SETTLE;
        end
        S_SETTLE: begin
          if (!pick_found) begin
            state_r <= S_MISS;
          end else if (pick_idx == e_r) begin
            cur_r   <= e_r;
            state_r <= S_PATH_RD;
          end else begin
            idx_r   <= '0;
            state_r <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (idx_r == LAST_IDX) begin
            state_r <= S_RELAX_END;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_RELAX_END: begin
          idx_r   <= '0;
          state_r <= S_SCAN;
        end
        S_PATH_RD: begin
          state_r <= S_PATH_EMIT;
        end
        S_PATH_EMIT: begin
          if (slot_free) begin
            out_node_r  <= FIELD_NODE_BITS'(cur_r);
            out_via_r   <= FIELD_NODE_BITS'(node_rd_r.pred);
            out_dist_r  <= dist_sat;
            out_found_r <= 1'b1;
            out_last_r  <= path_last;
            if (path_last) begin
              state_r <= S_IDLE;
            end else begin
              cur_r   <= node_rd_r.pred;
              k_r     <= k_r + 1'b1;
              state_r <= S_PATH_RD;
            end
          end
        end
        S_MISS: begin
          if (slot_free) begin
            out_node_r  <= end_raw_r;
            out_via_r   <= '0;
            out_dist_r  <= '0;
            out_found_r <= 1'b0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.path_node     = out_node_r;
  assign out_chan.via_node      = out_via_r;
  assign out_chan.path_distance = out_dist_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.last          = out_last_r;

  // a path in progress holds off new requests
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && !out_chan.last |-> !in_chan.ready)
    else $error("request taken in the middle of a path report");

  // an unreachable result is the only result of its query
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.found |-> out_chan.last)
    else $error("unreachable result without last");

  // relaxation never rewrites the node just settled
  assert property (@(posedge clk) disable iff (!rst_n)
    relax_upd |-> (rd_idx_r != pick_idx))
    else $error("relaxation hit the settled node");

  // the next result waits for a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid && $stable(out_chan.path_node))
    else $error("stalled result lost");

endmodule

// ----- bench/shortest_path_search_unit_tb.sv -----
`timescale 1ns / 100ps

module shortest_path_search_unit_tb;
  import sps_pkg::*;

  localparam int NODES      = NODE_COUNT_DEF;
  localparam int GAP_PCT    = 29;   // chance of an idle cycle on either side
  localparam int DRAIN_WAIT = 80;   // quiet cycles once nothing is outstanding
  localparam int RAND_ITEMS = 330;

  // the fourth request code has no meaning, the block must drop it
  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

  typedef logic [FIELD_NODE_BITS-1:0] node_t;

  // one pending request, hold makes the driver wait for an empty result queue
  typedef struct {
    logic [REQ_BITS-1:0]          req_type;
    node_t                        edge_from;
    node_t                        edge_to;
    logic [FIELD_WEIGHT_BITS-1:0] edge_weight;
    node_t                        start_node;
    node_t                        end_node;
    bit                           hold;
  } graph_req_t;

  // one reported path node
  typedef struct packed {
    node_t                    path_node;
    node_t                    via_node;
    logic [OUT_DIST_BITS-1:0] path_distance;
    logic                     found;
    logic                     last;
  } hop_t;

  logic clk;
  logic rst_n;

  sps_in_if  in_chan ();
  sps_out_if out_chan ();

  shortest_path_search_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  graph_req_t req_q[$];   // requests not yet offered
  hop_t       hop_q[$];   // path nodes still to come, oldest first

  // mirror of the adjacency store, indexed by from*NODES+to
  bit                           edge_on   [NODES*NODES];
  logic [FIELD_WEIGHT_BITS-1:0] edge_cost [NODES*NODES];

  int reqs_sent = 0;
  int errs      = 0;
  int hops_seen = 0;
  int n_load    = 0;
  int n_clear   = 0;
  int n_query   = 0;
  int n_unreach = 0;
  int n_ignored = 0;
  int longest   = 0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // append to the tail of the pending queues
  task automatic queue_req(input graph_req_t r);
    req_q.insert(req_q.size(), r);
  endtask

  task automatic queue_hop(input hop_t h);
    hop_q.insert(hop_q.size(), h);
  endtask

  // window with no idle cycles on either side
  function automatic bit no_gaps();
    return reqs_sent >= 140 && reqs_sent < 200;
  endfunction

  // dijkstra from src until dst is settled, queues the path end first
  task automatic search_path(input node_t src, input node_t dst);
    int unsigned              best [NODES];
    bit                       done [NODES];
    bit                       seen [NODES];
    node_t                    prev [NODES];
    int                       pick;
    int unsigned              cand;
    int                       k;
    node_t                    cur;
    bit                       fin;
    logic [OUT_DIST_BITS-1:0] sat;
    for (int i = 0; i < NODES; i++) begin
      best[i] = 0;
      done[i] = 1'b0;
      seen[i] = 1'b0;
      prev[i] = '0;
    end
    seen[src] = 1'b1;
    prev[src] = src;
    forever begin
      // lowest tentative distance, lowest index wins a tie
      pick = -1;
      for (int i = 0; i < NODES; i++) begin
        if (seen[i] && !done[i] && (pick < 0 || best[i] < best[pick]))
          pick = i;
      end
      if (pick < 0)
        break;
      done[pick] = 1'b1;
      if (pick == dst)
        break;
      for (int i = 0; i < NODES; i++) begin
        if (edge_on[pick*NODES + i] && !done[i]) begin
          cand = best[pick] + edge_cost[pick*NODES + i];
          // predecessor moves only on a strictly shorter distance
          if (!seen[i] || cand < best[i]) begin
            seen[i] = 1'b1;
            best[i] = cand;
            prev[i] = node_t'(pick);
          end
        end
      end
    end
    if (!done[dst]) begin
      queue_hop({dst, node_t'(0), OUT_DIST_BITS'(0), 1'b0, 1'b1});
      n_unreach++;
    end else begin
      cur = dst;
      k = 0;
      forever begin
        fin = (cur == src) || (k + 1 >= MAX_RESULTS) || (k + 1 >= NODES);
        sat = (best[cur] > DIST_SAT) ? DIST_SAT : OUT_DIST_BITS'(best[cur]);
        queue_hop({cur, prev[cur], sat, 1'b1, fin});
        k++;
        if (fin)
          break;
        cur = prev[cur];
      end
      if (k > longest)
        longest = k;
    end
  endtask

  // update the mirrored graph and queue what an accepted request yields
  task automatic apply_request(input graph_req_t r);
    case (r.req_type)
      REQ_LOAD: begin
        edge_on[r.edge_from*NODES + r.edge_to]   = 1'b1;
        edge_cost[r.edge_from*NODES + r.edge_to] = r.edge_weight;
        n_load++;
      end
      REQ_QUERY: begin
        search_path(r.start_node, r.end_node);
        n_query++;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < NODES*NODES; i++)
          edge_on[i] = 1'b0;
        n_clear++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // fields that a request does not use are random too
  function automatic graph_req_t any_req(input logic [REQ_BITS-1:0] kind, input bit hold);
    graph_req_t r;
    r.req_type    = kind;
    r.edge_from   = node_t'($urandom);
    r.edge_to     = node_t'($urandom);
    r.edge_weight = FIELD_WEIGHT_BITS'($urandom);
    r.start_node  = node_t'($urandom);
    r.end_node    = node_t'($urandom);
    r.hold        = hold;
    return r;
  endfunction

  task automatic add_load(input int from_n, input int to_n, input int w);
    graph_req_t r;
    r = any_req(REQ_LOAD, 1'b0);
    r.edge_from   = node_t'(from_n);
    r.edge_to     = node_t'(to_n);
    r.edge_weight = FIELD_WEIGHT_BITS'(w);
    queue_req(r);
  endtask

  task automatic add_query(input int s, input int e, input bit hold);
    graph_req_t r;
    r = any_req(REQ_QUERY, hold);
    r.start_node = node_t'(s);
    r.end_node   = node_t'(e);
    queue_req(r);
  endtask

  // request sender: one nonblocking update of valid per edge
  always @(posedge clk) begin : feed
    graph_req_t nxt;
    bit         go;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid)
        reqs_sent++;
      go = req_q.size() != 0 && (no_gaps() || $urandom_range(0, 99) >= GAP_PCT);
      // a held request goes out only from an idle cycle with no result pending
      if (go && req_q[0].hold)
        go = !in_chan.valid && hop_q.size() == 0;
      if (go) begin
        nxt = req_q.pop_front();
        in_chan.req_type    <= nxt.req_type;
        in_chan.edge_from   <= nxt.edge_from;
        in_chan.edge_to     <= nxt.edge_to;
        in_chan.edge_weight <= nxt.edge_weight;
        in_chan.start_node  <= nxt.start_node;
        in_chan.end_node    <= nxt.end_node;
      end
      in_chan.valid <= go;
    end
  end

  // result receiver stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= no_gaps() || $urandom_range(0, 99) >= GAP_PCT;
    end
  end

  // compare result transfers, then predict from request transfers
  always @(posedge clk) begin : watch
    hop_t       got;
    hop_t       want;
    graph_req_t taken;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.path_node, out_chan.via_node, out_chan.path_distance,
               out_chan.found, out_chan.last};
        hops_seen++;
        if (hop_q.size() == 0) begin
          errs++;
          $display("%0t: extra result, expected none, got %0d/%0d/%0d/%0d/%0d", $time,
                   got.path_node, got.via_node, got.path_distance, got.found, got.last);
        end else begin
          want = hop_q.pop_front();
          check_field("path_node", want.path_node, got.path_node);
          check_field("via_node", want.via_node, got.via_node);
          check_field("path_distance", want.path_distance, got.path_distance);
          check_field("found", want.found, got.found);
          check_field("last", want.last, got.last);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        taken.req_type    = in_chan.req_type;
        taken.edge_from   = in_chan.edge_from;
        taken.edge_to     = in_chan.edge_to;
        taken.edge_weight = in_chan.edge_weight;
        taken.start_node  = in_chan.start_node;
        taken.end_node    = in_chan.end_node;
        taken.hold        = 1'b0;
        apply_request(taken);
      end
    end
  end

  initial begin : run
    int order [NODES];
    int span;
    int wmax;
    int j;
    int tmp;
    int plan;

    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.req_type     = REQ_LOAD;
    in_chan.edge_from    = '0;
    in_chan.edge_to      = '0;
    in_chan.edge_weight  = '0;
    in_chan.start_node   = '0;
    in_chan.end_node     = '0;
    out_chan.ready       = 1'b0;

    // directed part
    add_query(3, 7, 1'b0);                  // empty graph, unreachable
    add_query(5, 5, 1'b0);                  // start equals end
    add_load(0, 15, 255);
    add_load(0, 8, 0);
    add_load(8, 15, 255);                   // equal length, predecessor must stay 0
    add_load(15, 15, 0);                    // self loop
    add_query(0, 15, 1'b0);
    add_load(8, 15, 254);                   // overwrite, now shorter through 8
    add_query(0, 15, 1'b0);
    add_load(15, 0, 7);
    add_query(15, 8, 1'b0);
    add_load(0, 3, 5);
    add_load(0, 2, 5);
    add_load(2, 9, 1);
    add_load(3, 9, 1);                      // settle tie between 2 and 3
    add_query(0, 9, 1'b0);
    add_query(9, 0, 1'b0);                  // no edges leave 9
    queue_req(any_req(REQ_UNUSED, 1'b0));
    add_query(0, 15, 1'b0);
    queue_req(any_req(REQ_CLEAR, 1'b1));
    add_query(0, 15, 1'b0);                 // gone after clear
    add_query(15, 15, 1'b0);
    add_query(0, 0, 1'b1);

    // random graphs, each followed by a burst of queries
    while (req_q.size() < RAND_ITEMS) begin
      span = $urandom_range(2, NODES - 1);
      case ($urandom_range(0, 4))
        0:       wmax = 0;
        1:       wmax = 1;
        2:       wmax = 3;
        3:       wmax = 15;
        default: wmax = 255;
      endcase
      for (int i = 0; i < NODES; i++)
        order[i] = i;
      for (int i = NODES - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      if ($urandom_range(0, 1) == 0)
        queue_req(any_req(REQ_CLEAR, $urandom_range(0, 5) == 0));
      // a chain through shuffled nodes gives long paths
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < span; i++)
          add_load(order[i], order[i+1], $urandom_range(0, wmax));
        add_query(order[0], order[span], 1'b0);
      end
      repeat ($urandom_range(span / 2, 2 * span))
        add_load(order[$urandom_range(0, span)], order[$urandom_range(0, span)],
                 $urandom_range(0, wmax));
      // noise
      if ($urandom_range(0, 7) == 0)
        queue_req(any_req(REQ_UNUSED, 1'b0));
      if ($urandom_range(0, 7) == 0)
        add_load($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                 $urandom_range(0, 255));
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 4) == 0)
          add_query($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), 1'b0);
        else
          add_query(order[$urandom_range(0, span)], order[$urandom_range(0, span)],
                    $urandom_range(0, 9) == 0);
      end
    end
    plan = req_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // all requests out, all results back, then a quiet stretch
    while (reqs_sent < plan)
      @(posedge clk);
    while (hop_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d requests: %0d loads, %0d clears, %0d queries, %0d ignored",
             reqs_sent, n_load, n_clear, n_query, n_ignored);
    $display("%0d unreachable, %0d path nodes compared, longest %0d nodes, %0d mismatches",
             n_unreach, hops_seen, longest, errs);
    if (errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d requests sent and %0d results pending", reqs_sent,
             hop_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
